// ===== hdl/rba_pkg.sv =====
// Shared types, constants and helpers for the region bump allocator.
// No dependencies; imported by every module of the block.
package rba_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int PTR_W       = 33;
   localparam int SIZE_W      = 34;
   localparam int REQ_W       = 24;
   localparam int MISS_W      = 8;

   localparam logic [REQ_W-1:0]  DEFAULT_SIZE = REQ_W'(512);
   localparam logic [MISS_W-1:0] MISS_SAT     = 8'd255;
   localparam logic [SIZE_W-1:0] MAX_SPAN     = 34'h2_0000_0000;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   localparam logic [1:0] REG_INITIAL_SIZE  = 2'd0;
   localparam logic [1:0] REG_RETIRE_LIMIT  = 2'd1;
   localparam logic [1:0] REG_BACKING_BASE  = 2'd2;
   localparam logic [1:0] REG_BACKING_LIMIT = 2'd3;

   typedef struct packed {
      logic [PTR_W-1:0]  free_ptr;
      logic [PTR_W-1:0]  end_ptr;
      logic [MISS_W-1:0] misses;
   } entry_type;

   typedef struct packed {
      logic [REQ_W-1:0]  initial_size;
      logic [MISS_W-1:0] retire_limit;
      logic [31:0]       backing_base;
      logic [31:0]       backing_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] address;
      logic [1:0]  status;
      logic        new_region;
   } result_type;

   function automatic logic span_fits(input logic [PTR_W-1:0]  base,
                                      input logic [SIZE_W-1:0] sz,
                                      input logic [31:0]       limit);
      logic [SIZE_W:0] last_addr;
      last_addr = {2'b00, base} + {1'b0, sz} - 35'd1;
      return (sz != '0) && (sz <= MAX_SPAN) && (last_addr <= {3'b000, limit});
   endfunction

endpackage

// ===== hdl/rba_table.sv =====
// Region table memory: one write port, one read port, registered read data.
// Depends on rba_pkg for the entry type and depth.
module rba_table
   import rba_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [MAX_REGIONS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rba_ctrl.sv =====
// Allocation sequencer: rebuild, first-fit walk over the region table, carve,
// and the result register. Depends on rba_pkg and rba_table.
module rba_ctrl
   import rba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_mode,
   input  logic [REQ_W-1:0] req_size,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output result_type       rsp_result
);

   localparam logic [2:0] ST_REBUILD = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_WALK    = 3'd2;
   localparam logic [2:0] ST_CARVE   = 3'd3;
   localparam logic [2:0] ST_OUT     = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic             silent_ff, silent_in;
   logic             first_ff, first_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] next_ff, next_in;
   logic [PTR_W-1:0] last_size_ff, last_size_in;
   logic [REQ_W-1:0] req_ff, req_in;
   result_type       res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   logic              req_fire;
   logic [PTR_W-1:0]  room;
   logic              fit;
   logic              last_walk;
   logic              retire;
   logic [SIZE_W-1:0] size2;
   logic [SIZE_W-1:0] req4;
   logic [SIZE_W-1:0] carve_size;
   logic              carve_fits;
   logic [SIZE_W-1:0] first_size;
   logic              init_fits;
   logic [PTR_W-1:0]  base_ext;

   rba_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rd_addr    = (state_ff == ST_WALK) ? idx_ff + IDX_W'(1) : head_ff;

   assign room      = rd_data.end_ptr - rd_data.free_ptr;
   assign fit       = {{(PTR_W-REQ_W){1'b0}}, req_ff} <= room;
   assign last_walk = ({1'b0, idx_ff} + CNT_W'(1)) >= count_ff;
   assign retire    = first_ff && (rd_data.misses > cfg.retire_limit)
                      && (({1'b0, head_ff} + CNT_W'(1)) < count_ff);

   assign size2      = {last_size_ff, 1'b0};
   assign req4       = {{(SIZE_W-REQ_W-2){1'b0}}, req_ff, 2'b00};
   assign carve_size = (size2 <= {{(SIZE_W-REQ_W){1'b0}}, req_ff}) ? req4 : size2;
   assign carve_fits = span_fits(next_ff, carve_size, cfg.backing_limit);

   assign base_ext   = {1'b0, cfg.backing_base};
   assign first_size = (cfg.initial_size != '0)
                       ? {{(SIZE_W-REQ_W){1'b0}}, cfg.initial_size}
                       : {{(SIZE_W-REQ_W){1'b0}}, DEFAULT_SIZE};
   assign init_fits  = span_fits(base_ext, first_size, cfg.backing_limit);

   always_comb begin
      state_in     = state_ff;
      silent_in    = silent_ff;
      first_in     = first_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      last_size_in = last_size_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;

      unique case (state_ff)
         ST_REBUILD: begin
            head_in = '0;
            if (init_fits) begin
               wr_en            = 1'b1;
               wr_addr          = '0;
               wr_data.free_ptr = base_ext;
               wr_data.end_ptr  = base_ext + first_size[PTR_W-1:0];
               wr_data.misses   = '0;
               count_in         = CNT_W'(1);
               next_in          = base_ext + first_size[PTR_W-1:0];
               last_size_in     = first_size[PTR_W-1:0];
               res_in           = '{address: cfg.backing_base, status: STATUS_OK,
                                    new_region: 1'b1};
            end else begin
               count_in = '0;
               next_in  = base_ext;
               res_in   = '{address: '0, status: STATUS_EXHAUSTED, new_region: 1'b0};
            end
            state_in  = silent_ff ? ST_IDLE : ST_OUT;
            silent_in = 1'b0;
         end
         ST_IDLE: begin
            if (req_fire) begin
               req_in   = req_size;
               idx_in   = head_ff;
               first_in = 1'b1;
               if (req_mode) begin
                  state_in = ST_REBUILD;
               end else if (count_ff == '0) begin
                  res_in   = '{address: '0, status: STATUS_EXHAUSTED, new_region: 1'b0};
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            first_in = 1'b0;
            if (retire) begin
               head_in = head_ff + IDX_W'(1);
            end
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (fit) begin
               wr_data.free_ptr = rd_data.free_ptr + {{(PTR_W-REQ_W){1'b0}}, req_ff};
               wr_data.misses   = '0;
               res_in   = '{address: rd_data.free_ptr[31:0], status: STATUS_OK,
                            new_region: 1'b0};
               state_in = ST_OUT;
            end else begin
               if (rd_data.misses != MISS_SAT) begin
                  wr_data.misses = rd_data.misses + MISS_W'(1);
               end
               if (last_walk) begin
                  state_in = ST_CARVE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_CARVE: begin
            if (count_ff >= CNT_W'(MAX_REGIONS)) begin
               res_in = '{address: '0, status: STATUS_FULL, new_region: 1'b0};
            end else if (!carve_fits) begin
               res_in = '{address: '0, status: STATUS_EXHAUSTED, new_region: 1'b0};
            end else begin
               wr_en            = 1'b1;
               wr_addr          = count_ff[IDX_W-1:0];
               wr_data.free_ptr = next_ff + {{(PTR_W-REQ_W){1'b0}}, req_ff};
               wr_data.end_ptr  = next_ff + carve_size[PTR_W-1:0];
               wr_data.misses   = '0;
               next_in          = next_ff + carve_size[PTR_W-1:0];
               last_size_in     = carve_size[PTR_W-1:0];
               count_in         = count_ff + CNT_W'(1);
               res_in           = '{address: next_ff[31:0], status: STATUS_OK,
                                    new_region: 1'b1};
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_REBUILD;
         silent_ff    <= 1'b1;
         first_ff     <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         silent_ff    <= silent_in;
         first_ff     <= first_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      next_ff      <= next_in;
      last_size_ff <= last_size_in;
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

endmodule

// ===== hdl/region_bump_allocator.sv =====
// Region bump allocator, top level: control/status registers and the sequencer.
// Depends on rba_pkg and rba_ctrl.
//
// Usage:
//   req_* channel: one beat per allocate (tuser = 0) or release-all (tuser = 1).
//   rsp_* channel: one beat per request with the address, status and new-region flag.
//   csr_* channel: register writes, taken every cycle; write only while idle.
// Path from request beat to response valid, by sequencer state:
//   release: REBUILD, then OUT loads the output register.
//   allocate hitting the k-th walked region (k = 1..16): WALK, then OUT.
//   allocate that walks all n regions from the head and carves: WALK, CARVE, OUT.
//   allocate on an empty table: OUT loads the output register directly.
// The walk examines one region per cycle through the registered read port of the
// region table memory; the next request is taken the cycle after its response is
// loaded into the output register, so requests are handled one at a time.
// Reset: registers take their reset values and the first cycle after reset
// rebuilds region 0; req_tready stays low during that cycle.
// A stalled response holds in the output register; the block takes the next
// request meanwhile and holds its result until the register frees up.
module region_bump_allocator
   import rba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] request_size
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] address
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] new_region
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   result_type rsp_result;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_INITIAL_SIZE:  cfg_in.initial_size  = csr_data[REQ_W-1:0];
            REG_RETIRE_LIMIT:  cfg_in.retire_limit  = csr_data[MISS_W-1:0];
            REG_BACKING_BASE:  cfg_in.backing_base  = csr_data;
            REG_BACKING_LIMIT: cfg_in.backing_limit = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{initial_size: DEFAULT_SIZE, retire_limit: 8'd8,
                     backing_base: 32'h0, backing_limit: 32'hFFFF_FFFF};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_size   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = rsp_result.address;
   assign rsp_tuser = {rsp_result.new_region, rsp_result.status};

endmodule
